@@ design/crsv_pkg.sv @@
// Shared constants for the Catmull-Rom strip vertex unit.
`timescale 1ns / 1ps
package crsv_pkg;

  // Fixed field widths
  localparam int K_W      = 7;
  localparam int HALF_W   = 16;
  localparam int OUT_W    = 20;
  localparam int UNIT_W   = 20;
  localparam int TEX_U_W  = 2;
  localparam int T_W      = 16;

  // Output saturation limits, Q15.4
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  // CORDIC vectoring setup
  localparam int CORDIC_ITERS    = 16;
  localparam int CORDIC_GAIN_INV = 39797;
  localparam int UNIT_ONE        = 65536;

  // Rounding offset for the Q.16 drop
  localparam int RND_HALF = 32768;

  // Register map
  localparam int REG_HALF_WIDTH   = 0;
  localparam int HALF_WIDTH_RESET = 16;

  // Texture codes, indexed by k mod 4
  localparam logic [1:0] TEX_NONE = 2'd0;
  localparam logic [1:0] TEX_U05  = 2'd1;
  localparam logic [1:0] TEX_U10  = 2'd2;
  localparam logic [1:0] TEX_U05V = 2'd3;

  localparam logic [TEX_U_W-1:0] U_ZERO = 2'd0;
  localparam logic [TEX_U_W-1:0] U_HALF = 2'd1;
  localparam logic [TEX_U_W-1:0] U_ONE  = 2'd2;

endpackage

@@ design/crsv_if.sv @@
// Sample and vertex channel interfaces.
`timescale 1ns / 1ps
interface crsv_sample_if #(
  parameter int COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  p0_x;
  logic signed [COORD_BITS-1:0]  p0_y;
  logic signed [COORD_BITS-1:0]  p1_x;
  logic signed [COORD_BITS-1:0]  p1_y;
  logic signed [COORD_BITS-1:0]  p2_x;
  logic signed [COORD_BITS-1:0]  p2_y;
  logic signed [COORD_BITS-1:0]  p3_x;
  logic signed [COORD_BITS-1:0]  p3_y;
  logic [crsv_pkg::K_W-1:0]      step_index;

  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  step_index, input ready);
  modport sink   (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  step_index, output ready);
endinterface

interface crsv_vertex_if;
  logic                                valid;
  logic                                ready;
  logic signed [crsv_pkg::OUT_W-1:0]   plus_x;
  logic signed [crsv_pkg::OUT_W-1:0]   plus_y;
  logic signed [crsv_pkg::OUT_W-1:0]   minus_x;
  logic signed [crsv_pkg::OUT_W-1:0]   minus_y;
  logic                                has_texcoord;
  logic [crsv_pkg::TEX_U_W-1:0]        tex_u_halves;
  logic                                tex_v;

  modport source (output valid, plus_x, plus_y, minus_x, minus_y, has_texcoord,
                  tex_u_halves, tex_v, input ready);
  modport sink   (input valid, plus_x, plus_y, minus_x, minus_y, has_texcoord,
                  tex_u_halves, tex_v, output ready);
endinterface

@@ design/crsv_curve.sv @@
// Three-stage Horner evaluation of one curve axis.
`timescale 1ns / 1ps
module crsv_curve #(
  parameter int HW = 30
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [HW-1:0]          a,
  input  logic signed [HW-1:0]          b,
  input  logic signed [HW-1:0]          c,
  input  logic signed [HW-1:0]          p1s,
  input  logic signed [HW-1:0]          p2s,
  input  logic [crsv_pkg::T_W-1:0]      t,
  output logic signed [HW-1:0]          h,
  output logic signed [HW-1:0]          p2d
);
  localparam int PW = HW + crsv_pkg::T_W + 1;

  logic signed [HW-1:0] h1, h2, a_d1, p1_d1, p1_d2, p2_d1, p2_d2;
  logic [crsv_pkg::T_W-1:0] t_d1, t_d2;
  logic signed [PW-1:0] m1, m2, m3;

  // Round a Q.16 product back to the coefficient scale
  function automatic logic signed [HW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = (v + PW'(crsv_pkg::RND_HALF)) >>> 16;
    return s[HW-1:0];
  endfunction

  assign m1 = PW'(c)  * $signed({1'b0, t});
  assign m2 = PW'(h1) * $signed({1'b0, t_d1});
  assign m3 = PW'(h2) * $signed({1'b0, t_d2});

  // Advance the Horner chain one step a stage
  always_ff @(posedge clk) begin
    if (en) begin
      h1    <= b + rnd(m1);
      a_d1  <= a;
      p1_d1 <= p1s;
      p2_d1 <= p2s;
      t_d1  <= t;
      h2    <= a_d1 + rnd(m2);
      p1_d2 <= p1_d1;
      p2_d2 <= p2_d1;
      t_d2  <= t_d1;
      h     <= p1_d2 + rnd(m3);
      p2d   <= p2_d2;
    end
  end
endmodule

@@ design/crsv_cordic.sv @@
// Pipelined CORDIC vectoring: unit vector along (dx, dy), one iteration per stage.
`timescale 1ns / 1ps
module crsv_cordic #(
  parameter int HW = 30
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [HW-1:0]                 dx,
  input  logic signed [HW-1:0]                 dy,
  output logic signed [crsv_pkg::UNIT_W-1:0]   ux,
  output logic signed [crsv_pkg::UNIT_W-1:0]   uy
);
  localparam int CW = HW + 10;
  localparam int N  = crsv_pkg::CORDIC_ITERS;
  localparam int UW = crsv_pkg::UNIT_W;

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [UW-1:0] cxs [N+1];
  logic signed [UW-1:0] cys [N+1];
  logic [N:0]           zero;

  logic signed [CW-1:0] dxw, dyw;
  assign dxw = CW'(dx) <<< 8;
  assign dyw = CW'(dy) <<< 8;

  // Fold the left half-plane onto the right and load the start vector
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        xs[0]  <= -dxw;
        ys[0]  <= -dyw;
        cxs[0] <= -UW'(crsv_pkg::CORDIC_GAIN_INV);
      end else begin
        xs[0]  <= dxw;
        ys[0]  <= dyw;
        cxs[0] <= UW'(crsv_pkg::CORDIC_GAIN_INV);
      end
      cys[0] <= '0;
    end
  end

  // Rotate toward the x axis, counter-rotate the start vector
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] >= 0) begin
          xs[i+1]  <= xs[i] + (ys[i] >>> i);
          ys[i+1]  <= ys[i] - (xs[i] >>> i);
          cxs[i+1] <= cxs[i] - (cys[i] >>> i);
          cys[i+1] <= cys[i] + (cxs[i] >>> i);
        end else begin
          xs[i+1]  <= xs[i] - (ys[i] >>> i);
          ys[i+1]  <= ys[i] + (xs[i] >>> i);
          cxs[i+1] <= cxs[i] + (cys[i] >>> i);
          cys[i+1] <= cys[i] - (cxs[i] >>> i);
        end
      end
    end
  end

  // Coincident points give the x axis
  assign ux = zero[N] ? UW'(crsv_pkg::UNIT_ONE) : cxs[N];
  assign uy = zero[N] ? '0 : cys[N];
endmodule

@@ design/crsv_offset.sv @@
// Two-stage offset of one axis: scale the direction, add and subtract, round, saturate.
`timescale 1ns / 1ps
module crsv_offset #(
  parameter int HW = 30
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [HW-1:0]                 h,
  input  logic signed [crsv_pkg::UNIT_W-1:0]   u,
  input  logic [crsv_pkg::HALF_W-1:0]          w,
  output logic signed [crsv_pkg::OUT_W-1:0]    plus,
  output logic signed [crsv_pkg::OUT_W-1:0]    minus
);
  localparam int UW = crsv_pkg::UNIT_W;
  localparam int PW = UW + crsv_pkg::HALF_W + 1;
  localparam int SW = ((HW + 7 > PW) ? HW + 7 : PW) + 1;
  localparam int RW = SW - 16;
  localparam logic signed [RW-1:0] R_MAX = RW'(crsv_pkg::OUT_MAX);
  localparam logic signed [RW-1:0] R_MIN = RW'(crsv_pkg::OUT_MIN);

  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] hs;
  logic signed [SW-1:0] sp, sm;
  logic signed [RW-1:0] rp, rm;

  function automatic logic signed [crsv_pkg::OUT_W-1:0] sat(
      input logic signed [RW-1:0] v);
    logic signed [crsv_pkg::OUT_W-1:0] r;
    if (v > R_MAX)      r = R_MAX[crsv_pkg::OUT_W-1:0];
    else if (v < R_MIN) r = R_MIN[crsv_pkg::OUT_W-1:0];
    else                r = v[crsv_pkg::OUT_W-1:0];
    return r;
  endfunction

  // Scale the direction by the half width
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(u) * $signed({1'b0, w});
      hs   <= SW'(h) <<< 7;
    end
  end

  assign sp = (hs + SW'(prod) + SW'(crsv_pkg::RND_HALF)) >>> 16;
  assign sm = (hs - SW'(prod) + SW'(crsv_pkg::RND_HALF)) >>> 16;
  assign rp = sp[RW-1:0];
  assign rm = sm[RW-1:0];

  // Round to Q.4 and clamp into the output range
  always_ff @(posedge clk) begin
    if (en) begin
      plus  <= sat(rp);
      minus <= sat(rm);
    end
  end
endmodule

@@ design/catmull_rom_strip_vertex_unit.sv @@
// Catmull-Rom strip vertex unit: top level with register port and valid pipeline.
//
// Usage: the sample channel carries four control points (signed Q11.4) and a
// step index k; the vertex channel returns the curve point at t = k/STEPS (k
// clamped to STEPS-1) pushed by +half_width and -half_width along the unit
// vector toward p2, saturated to signed Q15.4, plus the texture pair selected by k mod 4.
// half_width sits at APB byte address 0 (reset 16, i.e. 1.0); write it
// only while the pipeline is empty.
// The path from sample transaction to vertex valid is one input
// stage, three Horner stages, one fold stage and sixteen CORDIC stages,
// then two offset stages. Throughput is one transaction per cycle; every
// stage carries a valid bit.
// Reset empties the pipeline and reloads half_width. When the receiver
// stalls, all stages hold and sample ready drops; bubbles are kept in place
// so nothing is lost or repeated.
`timescale 1ns / 1ps
module catmull_rom_strip_vertex_unit #(
  parameter int STEPS      = 100,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  crsv_sample_if.sink           sample,
  crsv_vertex_if.source         vertex,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int HW    = COORD_BITS + 14;
  localparam int LAT   = 23;
  localparam int HLAT  = 17;
  localparam int NK    = 1 << crsv_pkg::K_W;
  localparam int UW    = crsv_pkg::UNIT_W;

  logic                           en;
  logic [LAT-1:0]                 vld;
  logic [crsv_pkg::HALF_W-1:0]    half_width;

  // Register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= crsv_pkg::HALF_W'(crsv_pkg::HALF_WIDTH_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == 1'(crsv_pkg::REG_HALF_WIDTH))) begin
      half_width <= pwdata[crsv_pkg::HALF_W-1:0];
    end
  end
  assign prdata = (paddr[2] == 1'(crsv_pkg::REG_HALF_WIDTH)) ?
                  {16'd0, half_width} : 32'd0;

  // Advance the whole pipeline unless the output slot is held
  assign en           = !vld[LAT-1] || vertex.ready;
  assign sample.ready = en;
  assign vertex.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  // Parameter table, built at elaboration
  logic [crsv_pkg::T_W-1:0] t_tab [NK];
  for (genvar i = 0; i < NK; i++) begin : g_ttab
    localparam int KC = (i < STEPS) ? i : STEPS - 1;
    localparam int TV = (KC * 65536) / STEPS;
    assign t_tab[i] = crsv_pkg::T_W'(TV);
  end

  // Input stage: coefficients per axis
  logic signed [HW-1:0] q0x, q0y, q1x, q1y, q2x, q2y, q3x, q3y;
  assign q0x = HW'(sample.p0_x);
  assign q0y = HW'(sample.p0_y);
  assign q1x = HW'(sample.p1_x);
  assign q1y = HW'(sample.p1_y);
  assign q2x = HW'(sample.p2_x);
  assign q2y = HW'(sample.p2_y);
  assign q3x = HW'(sample.p3_x);
  assign q3y = HW'(sample.p3_y);

  logic signed [HW-1:0] ax, bx, cx, p1sx, p2sx, ay, by, cy, p1sy, p2sy;
  logic [crsv_pkg::T_W-1:0] t_r;
  logic [1:0] tex_d [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ax   <= (q2x - q0x) <<< 8;
      bx   <= ((q0x <<< 1) - (q1x <<< 2) - q1x + (q2x <<< 2) - q3x) <<< 8;
      cx   <= ((q1x <<< 1) + q1x - (q2x <<< 1) - q2x + q3x - q0x) <<< 8;
      p1sx <= q1x <<< 9;
      p2sx <= q2x <<< 9;
      ay   <= (q2y - q0y) <<< 8;
      by   <= ((q0y <<< 1) - (q1y <<< 2) - q1y + (q2y <<< 2) - q3y) <<< 8;
      cy   <= ((q1y <<< 1) + q1y - (q2y <<< 1) - q2y + q3y - q0y) <<< 8;
      p1sy <= q1y <<< 9;
      p2sy <= q2y <<< 9;
      t_r  <= t_tab[sample.step_index];
      tex_d[0] <= sample.step_index[1:0];
    end
  end

  // Texture code rides alongside the data
  for (genvar i = 1; i < LAT; i++) begin : g_tex
    always_ff @(posedge clk) begin
      if (en) tex_d[i] <= tex_d[i-1];
    end
  end

  // Curve evaluation
  logic signed [HW-1:0] hx, hy, p2dx, p2dy;
  crsv_curve #(.HW(HW)) u_curve_x (
    .clk(clk), .en(en), .a(ax), .b(bx), .c(cx), .p1s(p1sx), .p2s(p2sx),
    .t(t_r), .h(hx), .p2d(p2dx)
  );
  crsv_curve #(.HW(HW)) u_curve_y (
    .clk(clk), .en(en), .a(ay), .b(by), .c(cy), .p1s(p1sy), .p2s(p2sy),
    .t(t_r), .h(hy), .p2d(p2dy)
  );

  // Direction toward p2
  logic signed [UW-1:0] ux, uy;
  crsv_cordic #(.HW(HW)) u_cordic (
    .clk(clk), .en(en), .dx(p2dx - hx), .dy(p2dy - hy), .ux(ux), .uy(uy)
  );

  // Hold the curve point while the direction is formed
  logic signed [HW-1:0] hxd [HLAT];
  logic signed [HW-1:0] hyd [HLAT];
  always_ff @(posedge clk) begin
    if (en) begin
      hxd[0] <= hx;
      hyd[0] <= hy;
    end
  end
  for (genvar i = 1; i < HLAT; i++) begin : g_hdly
    always_ff @(posedge clk) begin
      if (en) begin
        hxd[i] <= hxd[i-1];
        hyd[i] <= hyd[i-1];
      end
    end
  end

  // Offset and saturate
  crsv_offset #(.HW(HW)) u_offset_x (
    .clk(clk), .en(en), .h(hxd[HLAT-1]), .u(ux), .w(half_width),
    .plus(vertex.plus_x), .minus(vertex.minus_x)
  );
  crsv_offset #(.HW(HW)) u_offset_y (
    .clk(clk), .en(en), .h(hyd[HLAT-1]), .u(uy), .w(half_width),
    .plus(vertex.plus_y), .minus(vertex.minus_y)
  );

  // Texture pair
  always_comb begin
    vertex.has_texcoord = 1'b1;
    vertex.tex_u_halves = crsv_pkg::U_HALF;
    vertex.tex_v        = 1'b0;
    unique case (tex_d[LAT-1])
      crsv_pkg::TEX_NONE: begin
        vertex.has_texcoord = 1'b0;
        vertex.tex_u_halves = crsv_pkg::U_ZERO;
      end
      crsv_pkg::TEX_U05:  vertex.tex_u_halves = crsv_pkg::U_HALF;
      crsv_pkg::TEX_U10:  vertex.tex_u_halves = crsv_pkg::U_ONE;
      crsv_pkg::TEX_U05V: vertex.tex_v = 1'b1;
      default: vertex.has_texcoord = 1'b0;
    endcase
  end

`ifndef SYNTH
  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  // An accepted sample occupies the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[0])
    else $error("accepted sample lost at entry");

  // A stalled pipeline keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during stall");

  // Direction leaving the CORDIC has unit length within rounding
  a_unit_len: assert property (@(posedge clk) disable iff (rst)
    vld[20] |-> (ux <= UW'(66000)) && (ux >= -UW'(66000)) &&
                (uy <= UW'(66000)) && (uy >= -UW'(66000)))
    else $error("direction vector out of range");
`endif
endmodule

@@ dv/tb_top.sv @@
// Testbench for the Catmull-Rom strip vertex unit: predicts each vertex pair and checks it.
`timescale 1ns / 1ps
module tb_top;

  localparam int STEPS      = 100;
  localparam int COORD_BITS = 16;
  localparam int LATENCY    = 23;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [COORD_BITS-1:0] p [8];
    logic [crsv_pkg::K_W-1:0]     k;
  } sample_t;

  typedef struct {
    logic signed [crsv_pkg::OUT_W-1:0] plus_x, plus_y, minus_x, minus_y;
    logic                              has_tex;
    logic [crsv_pkg::TEX_U_W-1:0]      tex_u;
    logic                              tex_v;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  crsv_sample_if #(.COORD_BITS(COORD_BITS)) sample_ch ();
  crsv_vertex_if vertex_ch ();

  catmull_rom_strip_vertex_unit #(.STEPS(STEPS), .COORD_BITS(COORD_BITS)) i_dut (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .vertex(vertex_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  logic [crsv_pkg::HALF_W-1:0] model_half_width =
      crsv_pkg::HALF_W'(crsv_pkg::HALF_WIDTH_RESET);
  vertex_t           vertex_fifo[$];
  int                fail_count = 0;
  longint            cycle_count = 0;
  bit                rx_hold = 1'b0;

  // Floor shift and the Q.16 rounding drop
  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round16(longint v);
    return (v + crsv_pkg::RND_HALF) >>> 16;
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > crsv_pkg::OUT_MAX) return crsv_pkg::OUT_MAX;
    if (v < crsv_pkg::OUT_MIN) return crsv_pkg::OUT_MIN;
    return v;
  endfunction

  function automatic longint horner_axis(longint q0, longint q1, longint q2, longint q3,
                                         longint t);
    longint a, b, c, h;
    a = (q2 - q0) * 256;
    b = (2 * q0 - 5 * q1 + 4 * q2 - q3) * 256;
    c = (-q0 + 3 * q1 - 3 * q2 + q3) * 256;
    h = c;
    h = b + round16(h * t);
    h = a + round16(h * t);
    h = 2 * q1 * 256 + round16(h * t);
    return h;
  endfunction

  // Vectoring CORDIC that rotates the scaled start vector along with d
  task automatic unit_toward(input longint dx, input longint dy,
                             output longint ux, output longint uy);
    longint x, y, cx, cy, xs, ys, cxs, cys;
    if (dx == 0 && dy == 0) begin
      ux = crsv_pkg::UNIT_ONE;
      uy = 0;
      return;
    end
    x = dx * 256; y = dy * 256; cx = crsv_pkg::CORDIC_GAIN_INV; cy = 0;
    if (dx < 0) begin
      x = -x; y = -y; cx = -cx;
    end
    for (int i = 0; i < crsv_pkg::CORDIC_ITERS; i++) begin
      xs = fshr(x, i); ys = fshr(y, i); cxs = fshr(cx, i); cys = fshr(cy, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; cx = cx - cys; cy = cy + cxs;
      end else begin
        x = x - ys; y = y + xs; cx = cx + cys; cy = cy - cxs;
      end
    end
    ux = cx; uy = cy;
  endtask

  task automatic predict_vertex(input sample_t s, output vertex_t v);
    longint t, hx, hy, ux, uy, w;
    int kc;
    logic [1:0] m;
    kc = (s.k >= STEPS) ? STEPS - 1 : int'(s.k);
    t = (longint'(kc) * 65536) / STEPS;
    hx = horner_axis(s.p[0], s.p[2], s.p[4], s.p[6], t);
    hy = horner_axis(s.p[1], s.p[3], s.p[5], s.p[7], t);
    unit_toward(longint'(s.p[4]) * 512 - hx, longint'(s.p[5]) * 512 - hy, ux, uy);
    w = longint'(model_half_width);
    v.plus_x  = crsv_pkg::OUT_W'(clamp_out(round16(hx * 128 + ux * w)));
    v.plus_y  = crsv_pkg::OUT_W'(clamp_out(round16(hy * 128 + uy * w)));
    v.minus_x = crsv_pkg::OUT_W'(clamp_out(round16(hx * 128 - ux * w)));
    v.minus_y = crsv_pkg::OUT_W'(clamp_out(round16(hy * 128 - uy * w)));
    m = s.k[1:0];
    v.has_tex = (m != crsv_pkg::TEX_NONE);
    v.tex_u = (m == crsv_pkg::TEX_NONE) ? crsv_pkg::U_ZERO :
              ((m == crsv_pkg::TEX_U10) ? crsv_pkg::U_ONE : crsv_pkg::U_HALF);
    v.tex_v = (m == crsv_pkg::TEX_U05V);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    vertex_ch.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (rx_hold) begin
        vertex_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        rx_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        vertex_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vertex_ch.ready <= 1'b1;
      @(posedge clk iff vertex_ch.valid);
    end
  end

  // Compare each vertex transaction with the oldest prediction
  always @(posedge clk) begin
    vertex_t exp_v;
    if (!rst && vertex_ch.valid && vertex_ch.ready) begin
      if (vertex_fifo.size() == 0) begin
        $display("%0t: vertex with nothing expected", $time);
        fail_count++;
      end else begin
        exp_v = vertex_fifo.pop_front();
        if (vertex_ch.plus_x !== exp_v.plus_x || vertex_ch.plus_y !== exp_v.plus_y ||
            vertex_ch.minus_x !== exp_v.minus_x || vertex_ch.minus_y !== exp_v.minus_y ||
            vertex_ch.has_texcoord !== exp_v.has_tex ||
            vertex_ch.tex_u_halves !== exp_v.tex_u || vertex_ch.tex_v !== exp_v.tex_v) begin
          $display("%0t: mismatch expected %0d %0d %0d %0d %b %0d %b actual %0d %0d %0d %0d %b %0d %b",
                   $time, exp_v.plus_x, exp_v.plus_y, exp_v.minus_x, exp_v.minus_y,
                   exp_v.has_tex, exp_v.tex_u, exp_v.tex_v,
                   vertex_ch.plus_x, vertex_ch.plus_y, vertex_ch.minus_x, vertex_ch.minus_y,
                   vertex_ch.has_texcoord, vertex_ch.tex_u_halves, vertex_ch.tex_v);
          fail_count++;
        end
      end
    end
  end

  // Offer one sample and predict once it is accepted
  task automatic send_sample(input sample_t s, input bit no_gap = 1'b0);
    vertex_t v;
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.p0_x <= s.p[0]; sample_ch.p0_y <= s.p[1];
    sample_ch.p1_x <= s.p[2]; sample_ch.p1_y <= s.p[3];
    sample_ch.p2_x <= s.p[4]; sample_ch.p2_y <= s.p[5];
    sample_ch.p3_x <= s.p[6]; sample_ch.p3_y <= s.p[7];
    sample_ch.step_index <= s.k;
    @(posedge clk iff sample_ch.ready);
    predict_vertex(s, v);
    vertex_fifo = {vertex_fifo, v};
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (vertex_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write the register, then read it back
  task automatic write_half_width(input logic [crsv_pkg::HALF_W-1:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(crsv_pkg::REG_HALF_WIDTH * 4); pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    penable <= 1'b0; pwrite <= 1'b0;
    model_half_width = value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: readback expected %0d actual %0d", $time, value, prdata);
      fail_count++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic sample_t random_sample(int mode);
    sample_t s;
    int span;
    span = (mode == 0) ? 32767 : ((mode == 1) ? 2000 : 64);
    for (int i = 0; i < 8; i++) begin
      if (mode == 0) s.p[i] = COORD_BITS'($urandom);
      else s.p[i] = COORD_BITS'($urandom_range(0, 2 * span) - span);
    end
    s.k = ($urandom_range(0, 9) == 0) ? crsv_pkg::K_W'($urandom_range(100, 127))
                                      : crsv_pkg::K_W'($urandom_range(0, 99));
    return s;
  endfunction

  // Extremes, every texture code, sample number saturation, curve on p2
  task automatic test_directed();
    sample_t s;
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 8; i++) s.p[i] = (k[0]) ? 16'sh7fff : 16'sh8000;
      s.k = crsv_pkg::K_W'(k);
      send_sample(s);
    end
    for (int i = 0; i < 8; i++) s.p[i] = 16'sd100;
    s.k = 7'd0;  send_sample(s);
    s.k = 7'd99; send_sample(s);
    s.k = 7'd100; send_sample(s);
    s.k = 7'd127; send_sample(s);
    s.p[0] = 16'sh8000; s.p[1] = 16'sh7fff; s.p[2] = 16'sh7fff; s.p[3] = 16'sh8000;
    s.p[4] = 16'sh8000; s.p[5] = 16'sh7fff; s.p[6] = 16'sh7fff; s.p[7] = 16'sh8000;
    for (int k = 0; k < 4; k++) begin
      s.k = crsv_pkg::K_W'(k * 33); send_sample(s);
    end
    for (int i = 0; i < 8; i++) s.p[i] = 16'sd0;
    s.p[4] = -16'sd40; s.p[5] = 16'sd30; s.k = 7'd50; send_sample(s);
    s.k = 7'd1; send_sample(s);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_sample(random_sample($urandom_range(0, 2)));
    drain();
  endtask

  // Hold the receiver off so the pipeline fills and stalls the input
  task automatic test_backpressure();
    rx_hold = 1'b1;
    for (int n = 0; n < 80; n++) send_sample(random_sample(1), 1'b1);
    drain();
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.p0_x = '0; sample_ch.p0_y = '0; sample_ch.p1_x = '0; sample_ch.p1_y = '0;
    sample_ch.p2_x = '0; sample_ch.p2_y = '0; sample_ch.p3_x = '0; sample_ch.p3_y = '0;
    sample_ch.step_index = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    write_half_width(16'd0);
    test_directed();
    test_random(300);
    write_half_width(16'hffff);
    test_directed();
    test_random(300);
    write_half_width(16'($urandom));
    test_random(300);
    write_half_width(16'd40);
    test_random(300);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
